// File: hw/rtl/cofactor_determinant_macros.svh
`ifndef COFACTOR_DETERMINANT_MACROS_SVH
`define COFACTOR_DETERMINANT_MACROS_SVH

// same-cycle implication check
`define CD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cofactor_determinant check failed");

// next-cycle implication check
`define CD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cofactor_determinant check failed");

`endif

// File: hw/rtl/cofdet_pkg.sv
`default_nettype none
package cofdet_pkg;
   localparam int DEFAULT_MAX_ORDER = 4;
   localparam int CFG_WIDTH  = 3;
   localparam int ELEM_WIDTH = 16;
   localparam int DET_WIDTH  = 48;
   localparam int PROD_WIDTH = 64;
   localparam int FRAC_BITS  = 8;

   localparam logic signed [PROD_WIDTH-1:0] DET_MAX_ACC = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [PROD_WIDTH-1:0] DET_MIN_ACC = 64'shFFFF_8000_0000_0000;

   function automatic logic signed [DET_WIDTH-1:0] sat_det(
      input logic signed [PROD_WIDTH-1:0] x);
      logic signed [PROD_WIDTH-1:0] y;
      y = x;
      if (x > DET_MAX_ACC) begin
         y = DET_MAX_ACC;
      end else if (x < DET_MIN_ACC) begin
         y = DET_MIN_ACC;
      end
      return y[DET_WIDTH-1:0];
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/cofdet_mul.sv
`default_nettype none
module cofdet_mul (
   input  wire                                           clock,
   input  wire logic signed [cofdet_pkg::ELEM_WIDTH-1:0] op_a,
   input  wire logic signed [cofdet_pkg::DET_WIDTH-1:0]  op_b,
   output logic signed [cofdet_pkg::PROD_WIDTH-1:0]      prod
);
   logic signed [cofdet_pkg::PROD_WIDTH-1:0] prod_ff;
   logic signed [cofdet_pkg::PROD_WIDTH-1:0] prod_in;

   assign prod_in = cofdet_pkg::PROD_WIDTH'(op_a) * cofdet_pkg::PROD_WIDTH'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// File: hw/rtl/cofactor_determinant.sv
// channel   ports                                        transaction
// request   start, busy, req_element                     start && !busy, one element
// response  rsp_valid, rsp_determinant                   one-cycle strobe, no stall
// csr       csr_valid, csr_ready, csr_data               valid && ready, matrix size
//
// loading takes one cycle per element, row-major
// after the last element the expansion runs on one shared multiplier
// and one store read port
// busy is high during the expansion; the result strobe ends it
// synchronous reset clears the load count and sets the order to 4
`default_nettype none
module cofactor_determinant #(
   parameter int MAX_ORDER = cofdet_pkg::DEFAULT_MAX_ORDER
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  wire                                           start,
   output logic                                          busy,
   input  wire logic signed [cofdet_pkg::ELEM_WIDTH-1:0] req_element,
   output logic                                          rsp_valid,
   output logic signed [cofdet_pkg::DET_WIDTH-1:0]       rsp_determinant,
   input  wire                                           csr_valid,
   output logic                                          csr_ready,
   input  wire logic [cofdet_pkg::CFG_WIDTH-1:0]         csr_data
);
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int OW    = $clog2(MAX_ORDER + 1);
   localparam int NW    = $clog2(DEPTH + 1);
   localparam int EW    = ((LW > OW) ? LW : OW) + 2;
   localparam int DW    = cofdet_pkg::DET_WIDTH;
   localparam int PW    = cofdet_pkg::PROD_WIDTH;
   localparam int XW    = ((AW > NW) ? AW : NW) + OW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ENTER, ST_LEAF1_RD, ST_LEAF1_WT,
      ST_L2_A, ST_L2_B, ST_L2_C, ST_L2_D, ST_L2_E, ST_L2_F,
      ST_RET, ST_ACC_RD, ST_ACC_MUL, ST_ACC_SUM
   } state_type;

   state_type                          state_ff;
   logic [cofdet_pkg::CFG_WIDTH-1:0]   size_ff;
   logic [NW-1:0]                      count_ff;
   logic [LW-1:0]                      lvl_ff;
   logic [MAX_ORDER-1:0]               mask_ff [MAX_ORDER];
   logic [LW-1:0]                      col_ff  [MAX_ORDER];
   logic signed [DW-1:0]               sum_ff  [MAX_ORDER];
   logic                               neg_ff  [MAX_ORDER];
   logic [LW-1:0]                      c0_ff, c1_ff;
   logic signed [cofdet_pkg::ELEM_WIDTH-1:0] a_ff;
   logic signed [PW-1:0]               p1_ff;
   logic signed [DW-1:0]               sub_ff;
   logic                               rsp_valid_ff;
   logic signed [DW-1:0]               det_ff;

   logic signed [cofdet_pkg::ELEM_WIDTH-1:0] store_mem [DEPTH];
   logic signed [cofdet_pkg::ELEM_WIDTH-1:0] rdata_ff;

   logic [OW-1:0]        order_n;
   logic [NW-1:0]        total;
   logic [NW-1:0]        count_in;
   logic                 accept;
   logic                 last_elem;
   logic [MAX_ORDER-1:0] full_mask;
   logic [MAX_ORDER-1:0] cur_mask;
   logic [LW-1:0]        cur_col;
   logic [LW-1:0]        c0, c1, nxt;
   logic                 nxt_ok;
   logic [MAX_ORDER-1:0] mask_no_c0;
   logic                 is_k1, is_k2;
   logic [LW-1:0]        lvl_up;
   logic [LW-1:0]        rd_row, rd_col;
   logic [AW-1:0]        rd_addr;
   logic signed [cofdet_pkg::ELEM_WIDTH-1:0] mul_a;
   logic signed [DW-1:0] mul_b;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] term;
   logic signed [PW-1:0] acc_next;
   logic signed [DW-1:0] sum_next;

   always_comb begin
      if (size_ff == '0) begin
         order_n = OW'(1);
      end else if (32'(size_ff) > MAX_ORDER) begin
         order_n = OW'(MAX_ORDER);
      end else begin
         order_n = OW'(size_ff);
      end
   end

   assign total     = NW'(XW'(order_n) * XW'(order_n));
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy && !start;
   assign accept    = start && !busy;
   assign count_in  = count_ff + NW'(1);
   assign last_elem = (count_in == total);

   always_comb begin
      for (int i = 0; i < MAX_ORDER; i++) begin
         full_mask[i] = (OW'(i) < order_n);
      end
   end

   assign cur_mask = mask_ff[lvl_ff];
   assign cur_col  = col_ff[lvl_ff];
   assign lvl_up   = lvl_ff + LW'(1);

   always_comb begin
      c0 = '0;
      for (int i = MAX_ORDER - 1; i >= 0; i--) begin
         if (cur_mask[i]) begin
            c0 = LW'(i);
         end
      end
   end

   assign mask_no_c0 = cur_mask & ~(MAX_ORDER'(1) << c0);

   always_comb begin
      c1 = '0;
      for (int i = MAX_ORDER - 1; i >= 0; i--) begin
         if (mask_no_c0[i]) begin
            c1 = LW'(i);
         end
      end
   end

   always_comb begin
      nxt    = '0;
      nxt_ok = 1'b0;
      for (int i = MAX_ORDER - 1; i >= 0; i--) begin
         if (cur_mask[i] && (LW'(i) > cur_col)) begin
            nxt    = LW'(i);
            nxt_ok = 1'b1;
         end
      end
   end

   assign is_k1 = (EW'(lvl_ff) + EW'(1) == EW'(order_n));
   assign is_k2 = (EW'(lvl_ff) + EW'(2) == EW'(order_n));

   always_comb begin
      rd_row = lvl_ff;
      rd_col = c0_ff;
      case (state_ff)
         ST_L2_B: begin
            rd_row = lvl_up;
            rd_col = c1_ff;
         end
         ST_L2_C: begin
            rd_col = c1_ff;
         end
         ST_L2_D: begin
            rd_row = lvl_up;
         end
         ST_ACC_RD: begin
            rd_col = cur_col;
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = AW'(XW'(rd_row) * XW'(order_n) + XW'(rd_col));

   always_ff @(posedge clock) begin
      if (accept) begin
         store_mem[count_ff[AW-1:0]] <= req_element;
      end
      rdata_ff <= store_mem[rd_addr];
   end

   always_comb begin
      if (state_ff == ST_ACC_MUL) begin
         mul_a = rdata_ff;
         mul_b = sub_ff;
      end else begin
         mul_a = a_ff;
         mul_b = DW'(rdata_ff);
      end
   end

   cofdet_mul u_mul (
      .clock(clock),
      .op_a (mul_a),
      .op_b (mul_b),
      .prod (prod)
   );

   assign term     = prod >>> cofdet_pkg::FRAC_BITS;
   assign acc_next = neg_ff[lvl_ff] ? (PW'(sum_ff[lvl_ff]) - term)
                                    : (PW'(sum_ff[lvl_ff]) + term);
   assign sum_next = cofdet_pkg::sat_det(acc_next);

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               size_ff  <= csr_data;
               count_ff <= '0;
            end else if (accept) begin
               if (last_elem) begin
                  count_ff   <= '0;
                  lvl_ff     <= '0;
                  mask_ff[0] <= full_mask;
                  state_ff   <= ST_ENTER;
               end else begin
                  count_ff <= count_in;
               end
            end
         end
         ST_ENTER: begin
            c0_ff <= c0;
            c1_ff <= c1;
            if (is_k1) begin
               state_ff <= ST_LEAF1_RD;
            end else if (is_k2) begin
               state_ff <= ST_L2_A;
            end else begin
               sum_ff[lvl_ff]  <= '0;
               neg_ff[lvl_ff]  <= 1'b0;
               col_ff[lvl_ff]  <= c0;
               mask_ff[lvl_up] <= mask_no_c0;
               lvl_ff          <= lvl_up;
            end
         end
         ST_LEAF1_RD: begin
            state_ff <= ST_LEAF1_WT;
         end
         ST_LEAF1_WT: begin
            sub_ff   <= DW'(rdata_ff);
            state_ff <= ST_RET;
         end
         ST_L2_A: begin
            state_ff <= ST_L2_B;
         end
         ST_L2_B: begin
            a_ff     <= rdata_ff;
            state_ff <= ST_L2_C;
         end
         ST_L2_C: begin
            state_ff <= ST_L2_D;
         end
         ST_L2_D: begin
            a_ff     <= rdata_ff;
            p1_ff    <= term;
            state_ff <= ST_L2_E;
         end
         ST_L2_E: begin
            state_ff <= ST_L2_F;
         end
         ST_L2_F: begin
            sub_ff   <= cofdet_pkg::sat_det(p1_ff - term);
            state_ff <= ST_RET;
         end
         ST_RET: begin
            if (lvl_ff == '0) begin
               det_ff       <= sub_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end else begin
               lvl_ff   <= lvl_ff - LW'(1);
               state_ff <= ST_ACC_RD;
            end
         end
         ST_ACC_RD: begin
            state_ff <= ST_ACC_MUL;
         end
         ST_ACC_MUL: begin
            state_ff <= ST_ACC_SUM;
         end
         ST_ACC_SUM: begin
            sum_ff[lvl_ff] <= sum_next;
            neg_ff[lvl_ff] <= !neg_ff[lvl_ff];
            if (nxt_ok) begin
               col_ff[lvl_ff]  <= nxt;
               mask_ff[lvl_up] <= cur_mask & ~(MAX_ORDER'(1) << nxt);
               lvl_ff          <= lvl_up;
               state_ff        <= ST_ENTER;
            end else begin
               sub_ff   <= sum_next;
               state_ff <= ST_RET;
            end
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= cofdet_pkg::CFG_WIDTH'(4);
         count_ff     <= '0;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = det_ff;
endmodule
`default_nettype wire

// File: hw/rtl/cofdet_check.sv
`default_nettype none
`include "cofactor_determinant_macros.svh"
module cofdet_check (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_valid
);
   // expansion only begins after an accepted element
   `CD_ASSERT_IMP(a_busy_after_start, clock, reset, $rose(busy), $past(start))
   // the end of an expansion always delivers a result
   `CD_ASSERT_IMP(a_done_gives_result, clock, reset, $fell(busy), rsp_valid)
   `CD_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `CD_ASSERT_IMP(a_result_when_idle, clock, reset, rsp_valid, !busy)
endmodule

bind cofactor_determinant cofdet_check u_cofdet_check (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid)
);
`default_nettype wire

// File: test/cofactor_determinant_test.sv
`timescale 1ns / 1ps
module cofactor_determinant_test;

   localparam int QUIET_CYCLES = 200;
   localparam int STALL_LIMIT  = 4000;

   typedef enum logic [1:0] {OP_ELEM, OP_CFG, OP_DRAIN} op_kind_type;
   typedef struct {
      op_kind_type kind;
      logic [15:0] value;
      int idle_pct;
   } op_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [cofdet_pkg::ELEM_WIDTH-1:0] req_element = '0;
   logic rsp_valid;
   logic signed [cofdet_pkg::DET_WIDTH-1:0] rsp_determinant;
   logic csr_valid = 0;
   logic csr_ready;
   logic [cofdet_pkg::CFG_WIDTH-1:0] csr_data = '0;

   op_type pending_ops[$];
   logic signed [cofdet_pkg::DET_WIDTH-1:0] expected_dets[$];
   logic signed [cofdet_pkg::ELEM_WIDTH-1:0] loaded_elems[16];
   int load_cnt = 0;
   int order_n = 4;
   int quiet_cnt = 0;
   int stall_cnt = 0;
   int mismatches = 0;
   int cur_idle = 0;

   cofactor_determinant u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_element(req_element), .rsp_valid(rsp_valid),
      .rsp_determinant(rsp_determinant), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic longint elem_at(int r, int c);
      return longint'(loaded_elems[r * order_n + c]);
   endfunction

   // first-row cofactor expansion over rows r.. and the column set cols
   function automatic longint minor_det(int r, int cols, int k);
      longint sum;
      longint sub;
      int c0;
      int c1;
      int found;
      bit neg;
      sum = 0;
      c0 = 0;
      c1 = 0;
      found = 0;
      neg = 0;
      if (k <= 1) begin
         for (int c = 0; c < order_n; c++)
            if (cols[c]) return elem_at(r, c);
         return 0;
      end
      if (k == 2) begin
         for (int c = 0; c < order_n; c++) begin
            if (cols[c]) begin
               if (found == 0) c0 = c; else c1 = c;
               found++;
            end
         end
         return ((elem_at(r, c0) * elem_at(r + 1, c1)) >>> 8)
              - ((elem_at(r, c1) * elem_at(r + 1, c0)) >>> 8);
      end
      for (int c = 0; c < order_n; c++) begin
         if (cols[c]) begin
            sub = minor_det(r + 1, cols & ~(1 << c), k - 1);
            sub = (elem_at(r, c) * sub) >>> 8;
            sum = neg ? sum - sub : sum + sub;
            neg = !neg;
         end
      end
      return sum;
   endfunction

   task automatic load_element(input logic signed [15:0] v);
      longint det;
      loaded_elems[load_cnt] = v;
      load_cnt++;
      if (load_cnt >= order_n * order_n) begin
         load_cnt = 0;
         det = minor_det(0, (1 << order_n) - 1, order_n);
         expected_dets.push_back(det[cofdet_pkg::DET_WIDTH-1:0]);
      end
   endtask

   task automatic set_order(input logic [2:0] v);
      order_n = (v < 1) ? 1 : (v > 4) ? 4 : int'(v);
      load_cnt = 0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         csr_valid <= 0;
      end else begin
         if (start && !busy) load_element(req_element);
         if (csr_valid && csr_ready) set_order(csr_data);
         quiet_cnt = (expected_dets.size() == 0 && !busy) ? quiet_cnt + 1 : 0;
         if ((start && busy) || (csr_valid && !csr_ready)) begin
         end else if (pending_ops.size() == 0) begin
            start <= 0;
            csr_valid <= 0;
         end else if (pending_ops[0].kind == OP_ELEM) begin
            csr_valid <= 0;
            cur_idle = pending_ops[0].idle_pct;
            if ($urandom_range(99) < cur_idle) begin
               start <= 0;
            end else begin
               start <= 1;
               req_element <= pending_ops[0].value;
               void'(pending_ops.pop_front());
            end
         end else if (quiet_cnt > QUIET_CYCLES && !start) begin
            start <= 0;
            csr_valid <= (pending_ops[0].kind == OP_CFG);
            csr_data <= pending_ops[0].value[2:0];
            void'(pending_ops.pop_front());
         end else begin
            start <= 0;
            csr_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_dets.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected determinant %0d", rsp_determinant);
         end else begin
            if (rsp_determinant !== expected_dets[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("determinant mismatch: expected %0d actual %0d",
                           expected_dets[0], rsp_determinant);
            end
            void'(expected_dets.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || (csr_valid && csr_ready) || rsp_valid || reset)
         stall_cnt <= 0;
      else if (stall_cnt >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else
         stall_cnt <= stall_cnt + 1;
   end

   task automatic push_elem(input logic [15:0] v, input int idle);
      pending_ops.push_back('{OP_ELEM, v, idle});
   endtask

   task automatic push_cfg(input logic [2:0] v);
      pending_ops.push_back('{OP_CFG, {13'b0, v}, 0});
   endtask

   task automatic push_matrix(input int n, input int idle);
      logic [15:0] v;
      for (int i = 0; i < n * n; i++) begin
         v = 16'($urandom);
         if ($urandom_range(1)) v = 16'($urandom_range(1024)) - 16'd512;
         push_elem(v, idle);
      end
   endtask

   initial begin
      int sent;
      int n;
      logic [2:0] sz;
      int idles[4];
      idles = '{0, 64, 0, 32};
      // directed: reset order, extremes, identity, partial load
      for (int i = 0; i < 16; i++) push_elem((i % 5 == 0) ? 16'h0100 : 16'h0000, 0);
      for (int i = 0; i < 16; i++) push_elem(16'h7fff, 0);
      push_cfg(1);
      push_elem(16'h7fff, 0);
      push_elem(16'h8000, 0);
      push_cfg(2);
      push_elem(16'h7fff, 0);
      push_elem(16'h8000, 0);
      push_elem(16'h8000, 0);
      push_elem(16'h7fff, 0);
      push_elem(16'h1234, 0);
      push_cfg(0);
      push_elem(16'hffff, 0);
      push_cfg(3);
      push_matrix(3, 0);
      push_cfg(7);
      for (int i = 0; i < 16; i++) push_elem(16'h8000, 0);
      push_cfg(5);
      push_matrix(4, 0);
      for (int p = 0; p < 4; p++) begin
         sent = 0;
         while (sent < 250) begin
            sz = 3'($urandom_range(7));
            push_cfg(sz);
            n = (sz < 1) ? 1 : (sz > 4) ? 4 : int'(sz);
            for (int m = $urandom_range(6, 1); m > 0; m--) begin
               push_matrix(n, idles[p]);
               sent += n * n;
            end
            if ($urandom_range(3) == 0) begin
               push_matrix(1, idles[p]);
               sent++;
            end
         end
         pending_ops.push_back('{OP_DRAIN, 16'h0, 0});
      end
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (pending_ops.size() != 0 || start || csr_valid || expected_dets.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_dets.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
